// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the duplicate filter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another at the same edge
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/qhdf_pkg.sv
// Types, defaults and codes of the quotient hash duplicate filter
`timescale 1ns / 1ps

package qhdf_pkg;

   localparam int CELLS_DEF   = 1024;
   localparam int BUCKETS_DEF = 4;
   localparam int FP_BITS_DEF = 8;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_FILL  = 2'd1;
   localparam logic [1:0] ACT_EVICT = 2'd2;

   typedef struct packed {
      logic       op;
      logic [9:0] cell_index;
      logic [7:0] fingerprint;
      logic [1:0] victim_bucket;
   } req_type;

   typedef struct packed {
      logic       detected;
      logic [1:0] action;
   } rsp_type;

endpackage

// File: src/qhdf_ram.sv
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps

module qhdf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/quotient_hash_dedup_filter.sv
// Top level of the quotient hash duplicate filter
//
// Channels: req_ carries one item (operation, cell, fingerprint, victim bucket);
// rsp_ returns one result per item (detected flag, action taken). An item moves
// at a rising edge where valid is high and stall is low on its channel.
// The table sits in one RAM, one row of BUCKETS fingerprints per cell. An item
// reads its row when accepted, checks and updates it in the next cycle and
// writes it back; a back-to-back item on the same cell takes the row just
// written from a forwarding register instead of the RAM.
// Throughput: one item per cycle while req_stall is low, set by the single
// read-modify-write of the row RAM. Each result goes from the row update stage
// into the result buffer, is offered from there and can be taken at a rising edge.
// Reset: a clearing pass writes zero to every row, one row per cycle;
// req_stall stays high until it ends.
// Stall: a two-entry result buffer holds finished results; req_stall rises once
// the item in progress and the buffered results would fill it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quotient_hash_dedup_filter #(
   parameter int CELLS   = qhdf_pkg::CELLS_DEF,
   parameter int BUCKETS = qhdf_pkg::BUCKETS_DEF,
   parameter int FP_BITS = qhdf_pkg::FP_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qhdf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qhdf_pkg::rsp_type rsp_data
);

   import qhdf_pkg::*;

   localparam int CIDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int VIDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int ROW_W  = BUCKETS * FP_BITS;

   // clearing pass
   logic              clear_ff, clear_in;
   logic [CIDX_W-1:0] clr_cnt_ff, clr_cnt_in;

   // row update stage
   logic               s1_vld_ff, s1_vld_in;
   logic               s1_op_ff;
   logic [CIDX_W-1:0]  s1_cell_ff;
   logic [FP_BITS-1:0] s1_fp_ff;
   logic [VIDX_W-1:0]  s1_vic_ff;

   // forwarding of the last row written
   logic              last_vld_ff, last_vld_in;
   logic [CIDX_W-1:0] last_cell_ff;
   logic [ROW_W-1:0]  last_row_ff;

   // result buffer
   rsp_type    fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   logic              accept, pop;
   logic [1:0]        occ, occ_after;
   logic [CIDX_W-1:0] req_cell;
   logic [VIDX_W-1:0] req_vic;
   logic [ROW_W-1:0]  ram_rd_data, row, new_row;
   logic              ram_wr_en, item_wr;
   logic [CIDX_W-1:0] ram_wr_addr;
   logic [ROW_W-1:0]  ram_wr_data;
   logic              detected, have_empty;
   logic [VIDX_W-1:0] empty_slot;
   logic [1:0]        action;
   rsp_type           result;

   assign req_cell = CIDX_W'(32'(req_data.cell_index) % CELLS);
   assign req_vic  = VIDX_W'(32'(req_data.victim_bucket) % BUCKETS);

   // handshake and occupancy
   assign pop       = rsp_valid && !rsp_stall;
   assign occ       = count_ff + {1'b0, s1_vld_ff};
   assign occ_after = occ - {1'b0, pop};
   assign req_stall = clear_ff || (occ_after >= 2'd2);
   assign accept    = req_valid && !req_stall;

   qhdf_ram #(
      .WIDTH (ROW_W),
      .DEPTH (CELLS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (req_cell),
      .rd_data (ram_rd_data)
   );

   // check the row and work out the update
   always_comb begin
      row        = (last_vld_ff && last_cell_ff == s1_cell_ff) ? last_row_ff : ram_rd_data;
      detected   = 1'b0;
      have_empty = 1'b0;
      empty_slot = '0;
      for (int b = 0; b < BUCKETS; b++) begin
         if (row[b*FP_BITS +: FP_BITS] == s1_fp_ff) begin
            detected = 1'b1;
         end
         if (row[b*FP_BITS +: FP_BITS] == '0 && !have_empty) begin
            have_empty = 1'b1;
            empty_slot = VIDX_W'(b);
         end
      end
      new_row = row;
      action  = ACT_NONE;
      item_wr = 1'b0;
      if (s1_op_ff == OP_INSERT && !detected) begin
         item_wr = s1_vld_ff;
         if (have_empty) begin
            new_row[empty_slot*FP_BITS +: FP_BITS] = s1_fp_ff;
            action = ACT_FILL;
         end else begin
            new_row[s1_vic_ff*FP_BITS +: FP_BITS] = s1_fp_ff;
            action = ACT_EVICT;
         end
      end
      result.detected = detected;
      result.action   = action;
   end

   // write port: clearing pass first, then item updates
   always_comb begin
      if (clear_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = item_wr;
         ram_wr_addr = s1_cell_ff;
         ram_wr_data = new_row;
      end
   end

   always_comb begin
      clear_in   = clear_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clear_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CIDX_W'(CELLS - 1)) begin
            clear_in   = 1'b0;
            clr_cnt_in = '0;
         end
      end
      s1_vld_in   = accept;
      last_vld_in = s1_vld_ff;
      wr_ptr_in   = wr_ptr_ff ^ s1_vld_ff;
      rd_ptr_in   = rd_ptr_ff ^ pop;
      count_in    = count_ff + {1'b0, s1_vld_ff} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_cnt_ff  <= '0;
         s1_vld_ff   <= 1'b0;
         last_vld_ff <= 1'b0;
         wr_ptr_ff   <= 1'b0;
         rd_ptr_ff   <= 1'b0;
         count_ff    <= 2'd0;
      end else begin
         clear_ff    <= clear_in;
         clr_cnt_ff  <= clr_cnt_in;
         s1_vld_ff   <= s1_vld_in;
         last_vld_ff <= last_vld_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= req_data.op;
         s1_cell_ff <= req_cell;
         s1_fp_ff   <= FP_BITS'(req_data.fingerprint);
         s1_vic_ff  <= req_vic;
      end
      last_cell_ff <= s1_cell_ff;
      last_row_ff  <= new_row;
      if (s1_vld_ff) begin
         fifo_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   `ASSERT_ALWAYS(a_occ_bound, clock, reset,
      (3'(count_ff) + 3'(s1_vld_ff)) <= 3'd2, "result buffer overrun")
   `ASSERT_IMPLY(a_no_rsp_clear, clock, reset, clear_ff,
      !rsp_valid && !s1_vld_ff, "item active during clearing pass")
   `ASSERT_IMPLY(a_write_only_absent, clock, reset, rsp_valid && rsp_data.detected,
      rsp_data.action == ACT_NONE, "write reported for a detected item")

endmodule
